// ----- rtl/core/adcseq_pkg.sv -----
// Package for the ADC channel sequencer: state and result types, word decode
// constants and sequencer mode codes. No dependencies.
package adcseq_pkg;

    localparam int          NUM_CHANNELS_DEF = 8;
    localparam logic [15:0] RESET_MASK       = 16'hfffc;
    localparam logic [1:0]  MODE_SINGLE      = 2'h0;
    localparam logic [1:0]  MODE_SCAN_TEMP   = 2'h2;
    localparam logic [1:0]  MODE_SCAN        = 2'h3;
    localparam logic [3:0]  TEMP_SLOT        = 4'd8;
    localparam logic [2:0]  DEFAULT_LAST     = 3'd7;
    localparam int          CFG_BIT          = 15;
    localparam int          CHAN_LSB         = 9;
    localparam int          MODE_LSB         = 3;

    typedef struct packed {
        logic [3:0] tx_index;
        logic [3:0] acq_index;
        logic [3:0] seq_index;
        logic [2:0] last_channel;
        logic [1:0] scan_mode;
        logic       reset_seen;
    } t_seq_state;

    typedef struct packed {
        logic [3:0] tx_channel;
        logic [3:0] acq_channel;
        logic [3:0] next_channel;
        logic       reset_taken;
        logic       config_taken;
    } t_result;

endpackage

// ----- rtl/core/adc_spi_channel_sequencer.sv -----
// Top level of the ADC channel sequencer: input register, sequencer state,
// result register with skid stage. Depends on adcseq_pkg and adcseq_update.
//
//   channel  | handshake               | payload
//   input    | i_in_valid, o_in_stall  | i_rx_word
//   result   | o_out_valid, i_out_stall| o_tx_channel, o_acq_channel, o_next_channel,
//            |                         | o_reset_taken, o_config_taken
//
// One word per cycle is accepted unless o_in_stall is high; a word passes the input
// register and then the result register. The input register and the state update
// form the only path, so the rate is set by the combinational state update. Reset
// clears the pipeline and the sequencer state (last channel 7, scan mode). A result
// stalled at the output moves to a skid stage; input stalls only when both output stages are full.
module adc_spi_channel_sequencer
    import adcseq_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_rx_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_tx_channel,
    output logic [3:0]  o_acq_channel,
    output logic [3:0]  o_next_channel,
    output logic        o_reset_taken,
    output logic        o_config_taken
);

    logic        r_in_vld;
    logic [15:0] r_in_word;
    t_seq_state  r_state;
    t_seq_state  n_state;
    t_result     n_result;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_vld;
    logic        r_skid_vld;
    logic        proc;
    logic        take;
    logic        in_acc;

    adcseq_update #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_update (
        .i_state (r_state),
        .i_word  (r_in_word),
        .o_state (n_state),
        .o_result(n_result)
    );

    assign proc       = r_in_vld && !r_skid_vld;
    assign take       = r_out_vld && !i_out_stall;
    assign o_in_stall = r_in_vld && r_skid_vld;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld             <= 1'b0;
            r_out_vld            <= 1'b0;
            r_skid_vld           <= 1'b0;
            r_state.tx_index     <= 4'd0;
            r_state.acq_index    <= 4'd0;
            r_state.seq_index    <= 4'd0;
            r_state.last_channel <= DEFAULT_LAST;
            r_state.scan_mode    <= MODE_SCAN;
            r_state.reset_seen   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (take) begin
                if (r_skid_vld) begin
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= proc;
                end
            end else if (proc) begin
                if (r_out_vld) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_word <= i_rx_word;
        end
        if (take) begin
            r_out <= r_skid_vld ? r_skid : n_result;
        end else if (proc && !r_out_vld) begin
            r_out <= n_result;
        end
        if (!take && proc && r_out_vld) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_tx_channel   = r_out.tx_channel;
    assign o_acq_channel  = r_out.acq_channel;
    assign o_next_channel = r_out.next_channel;
    assign o_reset_taken  = r_out.reset_taken;
    assign o_config_taken = r_out.config_taken;

endmodule

// ----- rtl/core/adcseq_update.sv -----
// Next-state and result logic of the ADC channel sequencer for one word.
// Depends on adcseq_pkg.
module adcseq_update
    import adcseq_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  t_seq_state  i_state,
    input  logic [15:0] i_word,
    output t_seq_state  o_state,
    output t_result     o_result
);

    localparam logic [2:0] TOP_CH = 3'(NUM_CHANNELS - 1);

    logic       is_reset;
    logic       did_reset;
    logic       did_cfg;
    logic [2:0] chan;
    logic [1:0] mode;
    logic [2:0] limit;
    logic [3:0] seq_inc;
    t_seq_state n_st;

    assign is_reset = (i_word & RESET_MASK) == RESET_MASK;
    assign chan     = i_word[CHAN_LSB +: 3];
    assign mode     = i_word[MODE_LSB +: 2];
    assign limit    = (i_state.last_channel > TOP_CH) ? TOP_CH : i_state.last_channel;
    assign seq_inc  = i_state.seq_index + 4'd1;

    always_comb begin
        n_st           = i_state;
        n_st.tx_index  = i_state.acq_index;
        n_st.acq_index = i_state.seq_index;
        did_reset      = 1'b0;
        did_cfg        = 1'b0;
        if (is_reset) begin
            if (i_state.reset_seen) begin
                n_st.last_channel = DEFAULT_LAST;
                n_st.seq_index    = 4'd0;
                n_st.scan_mode    = MODE_SCAN;
                n_st.reset_seen   = 1'b0;
                did_reset         = 1'b1;
            end else begin
                n_st.reset_seen = 1'b1;
            end
        end else begin
            n_st.reset_seen = 1'b0;
            if (i_word[CFG_BIT]) begin
                did_cfg = 1'b1;
                case (mode)
                    MODE_SINGLE: begin
                        n_st.seq_index = {1'b0, (chan > TOP_CH) ? TOP_CH : chan};
                        n_st.scan_mode = MODE_SINGLE;
                    end
                    MODE_SCAN, MODE_SCAN_TEMP: begin
                        n_st.last_channel = chan;
                        n_st.seq_index    = 4'd0;
                        n_st.scan_mode    = mode;
                    end
                    default: begin
                    end
                endcase
            end else if (i_state.seq_index == TEMP_SLOT) begin
                n_st.seq_index = 4'd0;
            end else if (i_state.scan_mode == MODE_SCAN
                         || i_state.scan_mode == MODE_SCAN_TEMP) begin
                if (seq_inc > {1'b0, limit}) begin
                    n_st.seq_index = (i_state.scan_mode == MODE_SCAN) ? 4'd0 : TEMP_SLOT;
                end else begin
                    n_st.seq_index = seq_inc;
                end
            end
        end
    end

    assign o_state               = n_st;
    assign o_result.tx_channel   = n_st.tx_index;
    assign o_result.acq_channel  = n_st.acq_index;
    assign o_result.next_channel = n_st.seq_index;
    assign o_result.reset_taken  = did_reset;
    assign o_result.config_taken = did_cfg;

endmodule
